@@ hw/rtl/lbps_pkg.sv @@
// Types and constants shared across the light bar pair scorer.
`timescale 1ns / 1ps
package lbps_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_ANGLE_DIFF_MAX     = 3'd0;
    localparam logic [2:0] REG_LENGTH_RATIO_MAX   = 3'd1;
    localparam logic [2:0] REG_DISTANCE_RATIO_MIN = 3'd2;
    localparam logic [2:0] REG_DISTANCE_RATIO_MAX = 3'd3;
    localparam logic [2:0] REG_VERTICAL_RATIO_MAX = 3'd4;
    localparam logic [2:0] REG_LARGE_RATIO_THRESH = 3'd5;
    localparam logic [2:0] REG_LENGTH_WEIGHT      = 3'd6;
    localparam logic [2:0] REG_VERTICAL_WEIGHT    = 3'd7;

    localparam logic [11:0] RST_ANGLE_DIFF_MAX     = 12'd176;
    localparam logic [11:0] RST_LENGTH_RATIO_MAX   = 12'd102;
    localparam logic [11:0] RST_DISTANCE_RATIO_MIN = 12'd384;
    localparam logic [11:0] RST_DISTANCE_RATIO_MAX = 12'd1075;
    localparam logic [11:0] RST_VERTICAL_RATIO_MAX = 12'd154;
    localparam logic [11:0] RST_LARGE_RATIO_THRESH = 12'd640;
    localparam logic [7:0]  RST_LENGTH_WEIGHT      = 8'd50;
    localparam logic [7:0]  RST_VERTICAL_WEIGHT    = 8'd100;

    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_QUO_W = 21;

    localparam int FRONT_STAGES = 4;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_QUO_W + 1;

    localparam logic [16:0] SCORE_MAX = 17'd131071;

    typedef struct packed {
        logic [11:0] angle_diff_max;
        logic [11:0] length_ratio_max;
        logic [11:0] distance_ratio_min;
        logic [11:0] distance_ratio_max;
        logic [11:0] vertical_ratio_max;
        logic [11:0] large_ratio_threshold;
        logic [7:0]  length_weight;
        logic [7:0]  vertical_weight;
    } cfg_t;

    typedef struct packed {
        logic        pass;
        logic        big;
        logic [11:0] adiff;
    } tag_t;

endpackage

@@ hw/rtl/lbps_if.sv @@
// Valid/ready channel interfaces for bar pairs and scores.
`timescale 1ns / 1ps
interface lbps_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        first_center_x;
    logic [15:0]        first_center_y;
    logic signed [11:0] first_tilt;
    logic [15:0]        first_width;
    logic [15:0]        first_height;
    logic [15:0]        second_center_x;
    logic [15:0]        second_center_y;
    logic signed [11:0] second_tilt;
    logic [15:0]        second_width;
    logic [15:0]        second_height;

    modport source (
        output valid, first_center_x, first_center_y, first_tilt, first_width,
               first_height, second_center_x, second_center_y, second_tilt,
               second_width, second_height,
        input  ready
    );
    modport sink (
        input  valid, first_center_x, first_center_y, first_tilt, first_width,
               first_height, second_center_x, second_center_y, second_tilt,
               second_width, second_height,
        output ready
    );
endinterface

interface lbps_out_if;
    logic        valid;
    logic        ready;
    logic        is_pair;
    logic [16:0] match_score;
    logic        is_large;

    modport source (output valid, is_pair, match_score, is_large, input ready);
    modport sink (input valid, is_pair, match_score, is_large, output ready);
endinterface

@@ hw/rtl/lbps_front.sv @@
// Geometry, ratio tests and divider operands over four pipeline stages.
`timescale 1ns / 1ps
module lbps_front (
    input  logic                                   clk,
    input  logic                                   en,
    input  lbps_pkg::cfg_t                         cfg,
    input  logic [15:0]                            x1,
    input  logic [15:0]                            y1,
    input  logic signed [11:0]                     t1,
    input  logic [15:0]                            w1,
    input  logic [15:0]                            h1,
    input  logic [15:0]                            x2,
    input  logic [15:0]                            y2,
    input  logic signed [11:0]                     t2,
    input  logic [15:0]                            w2,
    input  logic [15:0]                            h2,
    output logic [lbps_pkg::DIV_NUM_W-1:0]         num_len,
    output logic [lbps_pkg::DIV_DEN_W-1:0]         den_len,
    output logic [lbps_pkg::DIV_NUM_W-1:0]         num_vert,
    output logic [lbps_pkg::DIV_DEN_W-1:0]         den_vert,
    output lbps_pkg::tag_t                         tag
);

    logic [15:0] len1;
    logic [15:0] len2;
    logic [12:0] td;
    logic [12:0] td_abs;

    logic [15:0] s1_longer_reg;
    logic [16:0] s1_lsum_reg;
    logic [11:0] s1_adiff_reg;
    logic [15:0] s1_ldiff_reg;
    logic [15:0] s1_dx_reg;
    logic [15:0] s1_dy_reg;

    logic [27:0] len_prod;
    logic [28:0] vert_prod;

    logic [31:0] s2_dx2_reg;
    logic [31:0] s2_dy2_reg;
    logic [28:0] s2_pmn_reg;
    logic [28:0] s2_pmx_reg;
    logic [28:0] s2_plt_reg;
    logic        s2_ok_reg;
    logic [23:0] s2_num_len_reg;
    logic [23:0] s2_num_vert_reg;
    logic [15:0] s2_longer_reg;
    logic [16:0] s2_lsum_reg;
    logic [11:0] s2_adiff_reg;

    logic [32:0] s3_dist_reg;
    logic [57:0] s3_smn_reg;
    logic [57:0] s3_smx_reg;
    logic [57:0] s3_slt_reg;
    logic        s3_ok_reg;
    logic [23:0] s3_num_len_reg;
    logic [23:0] s3_num_vert_reg;
    logic [15:0] s3_longer_reg;
    logic [16:0] s3_lsum_reg;
    logic [11:0] s3_adiff_reg;

    logic [57:0] dists;

    logic [23:0] s4_num_len_reg;
    logic [23:0] s4_num_vert_reg;
    logic [15:0] s4_longer_reg;
    logic [16:0] s4_lsum_reg;
    lbps_pkg::tag_t s4_tag_reg;

    assign len1   = (w1 > h1) ? w1 : h1;
    assign len2   = (w2 > h2) ? w2 : h2;
    assign td     = {t1[11], t1} - {t2[11], t2};
    assign td_abs = td[12] ? (13'd0 - td) : td;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_longer_reg <= (len1 > len2) ? len1 : len2;
            s1_lsum_reg   <= {1'b0, len1} + {1'b0, len2};
            s1_adiff_reg  <= td_abs[11:0];
            s1_ldiff_reg  <= (len1 > len2) ? (len1 - len2) : (len2 - len1);
            s1_dx_reg     <= (x1 > x2) ? (x1 - x2) : (x2 - x1);
            s1_dy_reg     <= (y1 > y2) ? (y1 - y2) : (y2 - y1);
        end
    end

    assign len_prod  = cfg.length_ratio_max * s1_longer_reg;
    assign vert_prod = cfg.vertical_ratio_max * s1_lsum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_dx2_reg      <= s1_dx_reg * s1_dx_reg;
            s2_dy2_reg      <= s1_dy_reg * s1_dy_reg;
            s2_pmn_reg      <= cfg.distance_ratio_min * s1_lsum_reg;
            s2_pmx_reg      <= cfg.distance_ratio_max * s1_lsum_reg;
            s2_plt_reg      <= cfg.large_ratio_threshold * s1_lsum_reg;
            s2_ok_reg       <= (s1_lsum_reg != 17'd0)
                            && (s1_adiff_reg <= cfg.angle_diff_max)
                            && (28'({s1_ldiff_reg, 8'd0}) <= len_prod)
                            && (29'({s1_dy_reg, 9'd0}) <= vert_prod);
            s2_num_len_reg  <= cfg.length_weight * s1_ldiff_reg;
            s2_num_vert_reg <= cfg.vertical_weight * s1_dy_reg;
            s2_longer_reg   <= s1_longer_reg;
            s2_lsum_reg     <= s1_lsum_reg;
            s2_adiff_reg    <= s1_adiff_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dist_reg     <= 33'(s2_dx2_reg) + 33'(s2_dy2_reg);
            s3_smn_reg      <= s2_pmn_reg * s2_pmn_reg;
            s3_smx_reg      <= s2_pmx_reg * s2_pmx_reg;
            s3_slt_reg      <= s2_plt_reg * s2_plt_reg;
            s3_ok_reg       <= s2_ok_reg;
            s3_num_len_reg  <= s2_num_len_reg;
            s3_num_vert_reg <= s2_num_vert_reg;
            s3_longer_reg   <= s2_longer_reg;
            s3_lsum_reg     <= s2_lsum_reg;
            s3_adiff_reg    <= s2_adiff_reg;
        end
    end

    assign dists = 58'({s3_dist_reg, 18'd0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_tag_reg.pass  <= s3_ok_reg && (dists >= s3_smn_reg)
                             && (dists <= s3_smx_reg);
            s4_tag_reg.big   <= dists > s3_slt_reg;
            s4_tag_reg.adiff <= s3_adiff_reg;
            s4_num_len_reg   <= s3_num_len_reg;
            s4_num_vert_reg  <= s3_num_vert_reg;
            s4_longer_reg    <= s3_longer_reg;
            s4_lsum_reg      <= s3_lsum_reg;
        end
    end

    assign num_len  = lbps_pkg::DIV_NUM_W'({s4_num_len_reg, 8'd0});
    assign num_vert = lbps_pkg::DIV_NUM_W'({s4_num_vert_reg, 9'd0});
    assign den_len  = lbps_pkg::DIV_DEN_W'(s4_longer_reg);
    assign den_vert = s4_lsum_reg;
    assign tag      = s4_tag_reg;

endmodule

@@ hw/rtl/lbps_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
`timescale 1ns / 1ps
module lbps_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [lbps_pkg::DIV_NUM_W-1:0] num,
    input  logic [lbps_pkg::DIV_DEN_W-1:0] den,
    input  lbps_pkg::tag_t                 tag_in,
    output logic [lbps_pkg::DIV_QUO_W-1:0] quo,
    output lbps_pkg::tag_t                 tag_out
);

    localparam int NW = lbps_pkg::DIV_NUM_W;
    localparam int DW = lbps_pkg::DIV_DEN_W;
    localparam int QW = lbps_pkg::DIV_QUO_W;
    localparam int CW = NW + DW + QW;

    logic [NW-1:0]  rem_reg [QW];
    logic [DW-1:0]  den_reg [QW];
    logic [QW-1:0]  quo_reg [QW];
    lbps_pkg::tag_t tag_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int B = QW - 1 - s;
        logic [NW-1:0]  rem_in;
        logic [DW-1:0]  den_in;
        logic [QW-1:0]  quo_in;
        lbps_pkg::tag_t tag_s;
        logic [CW-1:0]  sub;
        logic           take;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign tag_s  = tag_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign tag_s  = tag_reg[s-1];
        end

        assign sub  = CW'(den_in) << B;
        assign take = CW'(rem_in) >= sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? NW'(CW'(rem_in) - sub) : rem_in;
                den_reg[s] <= den_in;
                quo_reg[s] <= quo_in | (QW'(take) << B);
                tag_reg[s] <= tag_s;
            end
        end
    end

    assign quo     = quo_reg[QW-1];
    assign tag_out = tag_reg[QW-1];

endmodule

@@ hw/rtl/light_bar_pair_scorer.sv @@
// Top level: register port, scoring pipeline, output skid stage.
//
//   port        dir   words
//   pair_in     in    one pair of light bars
//   score_out   out   is_pair, match_score, is_large
//   apb         in    register writes and reads
//
// One word per cycle in while the skid is empty; each word passes front, divider and result registers.
// Depth is set by the 21-stage divider, one quotient bit per stage.
// Reset clears valid bits, output skid and registers to their defaults.
// A stall parks the last word in a skid register and holds every stage.
`timescale 1ns / 1ps
module light_bar_pair_scorer (
    input  logic                          clk,
    input  logic                          rst_n,
    lbps_in_if.sink                       pair_in,
    lbps_out_if.source                    score_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbps_pkg::ADDR_W-1:0]   paddr,
    input  logic [lbps_pkg::DATA_W-1:0]   pwdata,
    output logic [lbps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int N = lbps_pkg::PIPE_STAGES;

    lbps_pkg::cfg_t cfg_reg;
    logic           wr_en;

    logic [N-1:0] valid_reg;
    logic         en;

    logic [lbps_pkg::DIV_NUM_W-1:0] num_len;
    logic [lbps_pkg::DIV_DEN_W-1:0] den_len;
    logic [lbps_pkg::DIV_NUM_W-1:0] num_vert;
    logic [lbps_pkg::DIV_DEN_W-1:0] den_vert;
    lbps_pkg::tag_t                 front_tag;
    logic [lbps_pkg::DIV_QUO_W-1:0] quo_len;
    logic [lbps_pkg::DIV_QUO_W-1:0] quo_vert;
    lbps_pkg::tag_t                 len_tag;
    lbps_pkg::tag_t                 vert_tag;

    logic [22:0] score_sum;
    logic        res_pair_reg;
    logic [16:0] res_score_reg;
    logic        res_large_reg;
    logic        skid_valid_reg;
    logic        skid_pair_reg;
    logic [16:0] skid_score_reg;
    logic        skid_large_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_diff_max        <= lbps_pkg::RST_ANGLE_DIFF_MAX;
            cfg_reg.length_ratio_max      <= lbps_pkg::RST_LENGTH_RATIO_MAX;
            cfg_reg.distance_ratio_min    <= lbps_pkg::RST_DISTANCE_RATIO_MIN;
            cfg_reg.distance_ratio_max    <= lbps_pkg::RST_DISTANCE_RATIO_MAX;
            cfg_reg.vertical_ratio_max    <= lbps_pkg::RST_VERTICAL_RATIO_MAX;
            cfg_reg.large_ratio_threshold <= lbps_pkg::RST_LARGE_RATIO_THRESH;
            cfg_reg.length_weight         <= lbps_pkg::RST_LENGTH_WEIGHT;
            cfg_reg.vertical_weight       <= lbps_pkg::RST_VERTICAL_WEIGHT;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                lbps_pkg::REG_ANGLE_DIFF_MAX:
                    cfg_reg.angle_diff_max <= pwdata[11:0];
                lbps_pkg::REG_LENGTH_RATIO_MAX:
                    cfg_reg.length_ratio_max <= pwdata[11:0];
                lbps_pkg::REG_DISTANCE_RATIO_MIN:
                    cfg_reg.distance_ratio_min <= pwdata[11:0];
                lbps_pkg::REG_DISTANCE_RATIO_MAX:
                    cfg_reg.distance_ratio_max <= pwdata[11:0];
                lbps_pkg::REG_VERTICAL_RATIO_MAX:
                    cfg_reg.vertical_ratio_max <= pwdata[11:0];
                lbps_pkg::REG_LARGE_RATIO_THRESH:
                    cfg_reg.large_ratio_threshold <= pwdata[11:0];
                lbps_pkg::REG_LENGTH_WEIGHT:
                    cfg_reg.length_weight <= pwdata[7:0];
                lbps_pkg::REG_VERTICAL_WEIGHT:
                    cfg_reg.vertical_weight <= pwdata[7:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            lbps_pkg::REG_ANGLE_DIFF_MAX:     prdata = 32'(cfg_reg.angle_diff_max);
            lbps_pkg::REG_LENGTH_RATIO_MAX:   prdata = 32'(cfg_reg.length_ratio_max);
            lbps_pkg::REG_DISTANCE_RATIO_MIN: prdata = 32'(cfg_reg.distance_ratio_min);
            lbps_pkg::REG_DISTANCE_RATIO_MAX: prdata = 32'(cfg_reg.distance_ratio_max);
            lbps_pkg::REG_VERTICAL_RATIO_MAX: prdata = 32'(cfg_reg.vertical_ratio_max);
            lbps_pkg::REG_LARGE_RATIO_THRESH: prdata = 32'(cfg_reg.large_ratio_threshold);
            lbps_pkg::REG_LENGTH_WEIGHT:      prdata = 32'(cfg_reg.length_weight);
            lbps_pkg::REG_VERTICAL_WEIGHT:    prdata = 32'(cfg_reg.vertical_weight);
            default:                          prdata = '0;
        endcase
    end

    // advance the whole pipe unless a word is parked in the skid
    assign en            = !skid_valid_reg;
    assign pair_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[N-2:0], pair_in.valid};
        end
    end

    lbps_front u_front (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .x1       (pair_in.first_center_x),
        .y1       (pair_in.first_center_y),
        .t1       (pair_in.first_tilt),
        .w1       (pair_in.first_width),
        .h1       (pair_in.first_height),
        .x2       (pair_in.second_center_x),
        .y2       (pair_in.second_center_y),
        .t2       (pair_in.second_tilt),
        .w2       (pair_in.second_width),
        .h2       (pair_in.second_height),
        .num_len  (num_len),
        .den_len  (den_len),
        .num_vert (num_vert),
        .den_vert (den_vert),
        .tag      (front_tag)
    );

    lbps_div u_div_len (
        .clk     (clk),
        .en      (en),
        .num     (num_len),
        .den     (den_len),
        .tag_in  (front_tag),
        .quo     (quo_len),
        .tag_out (len_tag)
    );

    lbps_div u_div_vert (
        .clk     (clk),
        .en      (en),
        .num     (num_vert),
        .den     (den_vert),
        .tag_in  (front_tag),
        .quo     (quo_vert),
        .tag_out (vert_tag)
    );

    assign score_sum = 23'({vert_tag.adiff, 4'd0}) + 23'(quo_len) + 23'(quo_vert);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_pair_reg  <= len_tag.pass;
            res_large_reg <= len_tag.pass && len_tag.big;
            if (!len_tag.pass)
                res_score_reg <= '0;
            else if (score_sum > 23'(lbps_pkg::SCORE_MAX))
                res_score_reg <= lbps_pkg::SCORE_MAX;
            else
                res_score_reg <= score_sum[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (score_out.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (valid_reg[N-1] && !score_out.ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_pair_reg  <= res_pair_reg;
            skid_score_reg <= res_score_reg;
            skid_large_reg <= res_large_reg;
        end
    end

    assign score_out.valid       = skid_valid_reg || valid_reg[N-1];
    assign score_out.is_pair     = skid_valid_reg ? skid_pair_reg : res_pair_reg;
    assign score_out.match_score = skid_valid_reg ? skid_score_reg : res_score_reg;
    assign score_out.is_large    = skid_valid_reg ? skid_large_reg : res_large_reg;

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        score_out.valid && !score_out.is_pair
        |-> score_out.match_score == 17'd0 && !score_out.is_large)
        else $error("rejected pair carries score or large flag");

    a_large_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        score_out.valid && score_out.is_large |-> score_out.is_pair)
        else $error("large flag without pair");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !score_out.ready
        |=> skid_valid_reg && $stable(skid_score_reg) && $stable(skid_pair_reg))
        else $error("parked word lost");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(valid_reg))
        else $error("pipe moved while stalled");

endmodule
